>>> sv/lfsrpf_pkg.sv
`default_nettype none

package lfsrpf_pkg;

  // Register geometry
  localparam int unsigned MaxLength = 32;
  localparam int unsigned StateW    = MaxLength;
  localparam int unsigned LenW      = 6;
  localparam int unsigned CountW    = 32;
  localparam int unsigned DataW     = 32;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned PosW      = $clog2(MaxLength);

  // Configuration register map, word index into the APB space
  typedef enum logic [1:0] {
    RegLength = 2'd0,
    RegSeed   = 2'd1,
    RegTaps   = 2'd2,
    RegMode   = 2'd3
  } reg_idx_e;

  // Feedback styles
  typedef enum logic {
    ModeFibonacci = 1'b0,
    ModeGalois    = 1'b1
  } mode_e;

  // Per-request control shared by every bit cell
  typedef struct packed {
    logic load;
    logic advance;
  } cell_ctrl_t;

  // Control from the top level to the period counter
  typedef struct packed {
    logic load;
    logic advance;
    logic hit;
  } cnt_ctrl_t;

  // Clamp the programmed length to the supported range
  function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] len);
    logic [LenW-1:0] res;
    res = len;
    if (len < LenW'(2)) begin
      res = LenW'(2);
    end else if (len > LenW'(MaxLength)) begin
      res = LenW'(MaxLength);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> sv/lfsrpf_cell.sv
`default_nettype none

module lfsrpf_cell (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  lfsrpf_pkg::cell_ctrl_t  ctrl_i,
  input  wire                     active_i,
  input  wire                     seed_i,
  input  wire                     shift_i,
  input  wire                     flip_i,
  output logic                    bit_o,
  output logic                    match_o
);
  import lfsrpf_pkg::*;

  logic bit_q;
  logic bit_d;
  logic step_bit;
  logic seed_bit;

  // Mask off bits beyond the active length
  assign bit_o    = bit_q & active_i;
  assign seed_bit = seed_i & active_i;

  // Take the neighbor's bit, toggled by a Galois tap
  assign step_bit = (shift_i ^ flip_i) & active_i;
  assign match_o  = (step_bit == seed_bit);

  assign bit_d = ctrl_i.load ? seed_bit : step_bit;

  // Hold the bit unless a request loads or advances it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else if (ctrl_i.load || ctrl_i.advance) begin
      bit_q <= bit_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/lfsrpf_counter.sv
`default_nettype none

module lfsrpf_counter (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  lfsrpf_pkg::cnt_ctrl_t             ctrl_i,
  output logic [lfsrpf_pkg::CountW-1:0]     count_o
);
  import lfsrpf_pkg::*;

  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_d;
  logic [CountW-1:0] count_inc;

  // Count this step, saturating at all ones
  assign count_inc = (count_q == {CountW{1'b1}}) ? count_q : count_q + CountW'(1);
  assign count_o   = count_inc;

  // Clear on load or at a period end, else advance
  always_comb begin
    count_d = count_q;
    priority if (ctrl_i.load) begin
      count_d = '0;
    end else if (ctrl_i.advance) begin
      count_d = ctrl_i.hit ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  a_hit_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.advance && !ctrl_i.load && ctrl_i.hit |=> count_q == '0)
    else $error("period counter not cleared after period end");

  a_saturate_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.advance && !ctrl_i.load && !ctrl_i.hit && count_q == {CountW{1'b1}}
    |=> count_q == {CountW{1'b1}})
    else $error("saturated period counter moved");

endmodule

`default_nettype wire

>>> sv/configurable_lfsr_period_finder.sv
// A result is presented in the cycle after its request is accepted.
// Throughput: one request per cycle while the output is empty or draining;
// every bit cell and the period counter update in the accepting cycle.
// Reset: shift cells and period count clear to zero, registers take their
// defaults (length 32, seed 1, no taps, Fibonacci feedback), output empty.
`default_nettype none

module configurable_lfsr_period_finder (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // Input request channel
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire                              restart_i,
  // Result channel
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             out_bit_o,
  output logic                             period_end_o,
  output logic [lfsrpf_pkg::CountW-1:0]    step_count_o,
  // APB configuration port
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [lfsrpf_pkg::AddrW-1:0]     paddr,
  input  wire  [lfsrpf_pkg::DataW-1:0]     pwdata,
  output logic [lfsrpf_pkg::DataW-1:0]     prdata,
  output logic                             pready
);
  import lfsrpf_pkg::*;

  // Configuration registers
  logic [LenW-1:0]   length_q;
  logic [StateW-1:0] seed_q;
  logic [StateW-1:0] taps_q;
  mode_e             mode_q;

  reg_idx_e reg_idx;
  logic     cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= LenW'(32);
      seed_q   <= StateW'(1);
      taps_q   <= '0;
      mode_q   <= ModeFibonacci;
    end else if (cfg_write) begin
      unique case (reg_idx)
        RegLength: length_q <= pwdata[LenW-1:0];
        RegSeed:   seed_q   <= pwdata[StateW-1:0];
        RegTaps:   taps_q   <= pwdata[StateW-1:0];
        RegMode:   mode_q   <= mode_e'(pwdata[0]);
        default:   ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      RegLength: prdata = DataW'(length_q);
      RegSeed:   prdata = DataW'(seed_q);
      RegTaps:   prdata = DataW'(taps_q);
      RegMode:   prdata = DataW'(mode_q);
      default:   prdata = '0;
    endcase
  end

  // Handshake: accept whenever the output register is empty or draining
  logic out_valid_q;
  logic accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Effective length and the derived top position
  logic [LenW-1:0] len_eff;
  logic [PosW-1:0] top_pos;

  assign len_eff = eff_len(length_q);
  assign top_pos = PosW'(len_eff - LenW'(1));

  // Chain of bit cells
  cell_ctrl_t        cell_ctrl;
  logic [StateW-1:0] cell_bit;
  logic [StateW-1:0] cell_match;
  logic [StateW-1:0] cell_active;
  logic [StateW-1:0] cell_shift;
  logic [StateW-1:0] cell_flip;
  logic              top_bit;
  logic              fib_fb;
  logic              hit;

  assign cell_ctrl.load    = accept && restart_i;
  assign cell_ctrl.advance = accept && !restart_i;

  assign top_bit = cell_bit[top_pos];
  // Parity of tapped bits, position zero excluded
  assign fib_fb  = ^(cell_bit & {taps_q[StateW-1:1], 1'b0});
  assign hit     = &cell_match;

  for (genvar i = 0; i < StateW; i++) begin : g_cell
    assign cell_active[i] = (LenW'(i) < len_eff);

    if (i == 0) begin : g_first
      assign cell_shift[i] = (mode_q == ModeGalois) ? top_bit : fib_fb;
      assign cell_flip[i]  = 1'b0;
    end else if (i == 1) begin : g_second
      assign cell_shift[i] = cell_bit[i-1];
      assign cell_flip[i]  = 1'b0;
    end else begin : g_rest
      assign cell_shift[i] = cell_bit[i-1];
      assign cell_flip[i]  = (mode_q == ModeGalois) && top_bit && taps_q[i-1];
    end

    lfsrpf_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .active_i (cell_active[i]),
      .seed_i   (seed_q[i]),
      .shift_i  (cell_shift[i]),
      .flip_i   (cell_flip[i]),
      .bit_o    (cell_bit[i]),
      .match_o  (cell_match[i])
    );
  end

  // Period counter
  cnt_ctrl_t         cnt_ctrl;
  logic [CountW-1:0] step_count;

  assign cnt_ctrl.load    = cell_ctrl.load;
  assign cnt_ctrl.advance = cell_ctrl.advance;
  assign cnt_ctrl.hit     = hit;

  lfsrpf_counter u_counter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (cnt_ctrl),
    .count_o (step_count)
  );

  // Output register
  logic              out_bit_q;
  logic              period_end_q;
  logic [CountW-1:0] step_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_bit_q    <= !restart_i && top_bit;
      period_end_q <= !restart_i && hit;
      step_count_q <= restart_i ? '0 : step_count;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_bit_o    = out_bit_q;
  assign period_end_o = period_end_q;
  assign step_count_o = step_count_q;

  a_restart_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && restart_i |=> out_valid_o && !out_bit_o && !period_end_o
    && step_count_o == '0)
    else $error("restart result carries nonzero fields");

  a_end_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && period_end_o |-> step_count_o != '0)
    else $error("period end reported with zero step count");

  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output register empty");

endmodule

`default_nettype wire
